// ===== hdl/gmse_pkg.sv =====
`timescale 1ns / 1ps
package gmse_pkg;

    localparam int Q_W        = 64;
    localparam int FRAC_IN_W  = 33;
    localparam int CFG_IDX_W  = 3;
    localparam int S_TDATA_W  = 168;
    localparam int M_TDATA_W  = 456;
    localparam int MUL_LAT    = 3;
    localparam int DIV_LAT    = Q_W;
    localparam int SQRT_LAT   = Q_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAS_FRACTION_ERUPTED = 3'd0,
        REG_HEAT_CAPACITY_SOLID  = 3'd1,
        REG_HEAT_CAPACITY_GAS    = 3'd2,
        REG_HEAT_CAPACITY_AIR    = 3'd3,
        REG_GAS_CONSTANT_GAS     = 3'd4,
        REG_GAS_CONSTANT_AIR     = 3'd5
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_DIV_ZERO = 2'd1,
        ST_SAT      = 2'd2
    } status_t;

    typedef struct packed {
        logic sat;
        logic [Q_W-1:0] val;
    } qsum_t;

    typedef struct packed {
        status_t        status;
        logic [Q_W-1:0] erupted_density;
        logic [Q_W-1:0] air_density;
        logic [Q_W-1:0] mix_heat_capacity;
        logic [Q_W-1:0] temperature_out;
        logic [Q_W-1:0] sound_speed_out;
        logic [Q_W-1:0] gas_pressure;
        logic [Q_W-1:0] heat_ratio;
    } res_t;

    function automatic qsum_t q_add(input logic [Q_W-1:0] a, input logic [Q_W-1:0] b);
        logic [Q_W:0] s;
        qsum_t r;
        s = {1'b0, a} + {1'b0, b};
        r.sat = s[Q_W];
        r.val = s[Q_W] ? {Q_W{1'b1}} : s[Q_W-1:0];
        return r;
    endfunction

endpackage

// ===== hdl/gmse_delay.sv =====
`timescale 1ns / 1ps
module gmse_delay #(
    parameter int W = 1,
    parameter int D = 1
) (
    input  logic         aclk,
    input  logic         en,
    input  logic [W-1:0] din,
    output logic [W-1:0] dout
);
    logic [W-1:0] sr_reg [D];

    always_ff @(posedge aclk) begin
        if (en) begin
            sr_reg[0] <= din;
            for (int i = 1; i < D; i++) begin
                sr_reg[i] <= sr_reg[i-1];
            end
        end
    end

    assign dout = sr_reg[D-1];
endmodule

// ===== hdl/gmse_mul.sv =====
`timescale 1ns / 1ps
module gmse_mul #(
    parameter int FRAC_BITS = 32
) (
    input  logic                     aclk,
    input  logic                     en,
    input  logic [gmse_pkg::Q_W-1:0] a,
    input  logic [gmse_pkg::Q_W-1:0] b,
    output logic [gmse_pkg::Q_W-1:0] p,
    output logic                     sat
);
    import gmse_pkg::*;
    localparam int H = Q_W / 2;

    logic [Q_W-1:0]   pp0_reg, pp1_reg, pp2_reg, pp3_reg;
    logic [2*Q_W-1:0] prod_reg, prod_next;
    logic [Q_W-1:0]   p_reg;
    logic             sat_reg;

    assign prod_next = {pp3_reg, pp0_reg}
                     + {{H{1'b0}}, pp1_reg, {H{1'b0}}}
                     + {{H{1'b0}}, pp2_reg, {H{1'b0}}};

    always_ff @(posedge aclk) begin
        if (en) begin
            pp0_reg  <= a[H-1:0]   * b[H-1:0];
            pp1_reg  <= a[H-1:0]   * b[Q_W-1:H];
            pp2_reg  <= a[Q_W-1:H] * b[H-1:0];
            pp3_reg  <= a[Q_W-1:H] * b[Q_W-1:H];
            prod_reg <= prod_next;
            sat_reg  <= |prod_reg[2*Q_W-1:FRAC_BITS+Q_W];
            p_reg    <= (|prod_reg[2*Q_W-1:FRAC_BITS+Q_W]) ? {Q_W{1'b1}}
                                                          : prod_reg[FRAC_BITS +: Q_W];
        end
    end

    assign p   = p_reg;
    assign sat = sat_reg;
endmodule

// ===== hdl/gmse_div.sv =====
`timescale 1ns / 1ps
module gmse_div #(
    parameter int FRAC_BITS = 32
) (
    input  logic                     aclk,
    input  logic                     en,
    input  logic [gmse_pkg::Q_W-1:0] dividend,
    input  logic [gmse_pkg::Q_W-1:0] divisor,
    output logic [gmse_pkg::Q_W-1:0] quotient,
    output logic                     sat
);
    import gmse_pkg::*;

    logic [Q_W-1:0] rem_reg [DIV_LAT];
    logic [Q_W-1:0] lo_reg  [DIV_LAT];
    logic [Q_W-1:0] quo_reg [DIV_LAT];
    logic [Q_W-1:0] dvs_reg [DIV_LAT];
    logic           sat_reg [DIV_LAT];
    logic [Q_W-1:0] rem_init, lo_init;

    assign rem_init = dividend >> (Q_W - FRAC_BITS);
    assign lo_init  = dividend << FRAC_BITS;

    for (genvar i = 0; i < DIV_LAT; i++) begin : g_step
        logic [Q_W-1:0] rem_in, lo_in, quo_in, dvs_in;
        logic           sat_in, ge;
        logic [Q_W:0]   rem_sh, diff;
        if (i == 0) begin : g_first
            assign rem_in = rem_init;
            assign lo_in  = lo_init;
            assign quo_in = '0;
            assign dvs_in = divisor;
            assign sat_in = (rem_init >= divisor);
        end else begin : g_next
            assign rem_in = rem_reg[i-1];
            assign lo_in  = lo_reg[i-1];
            assign quo_in = quo_reg[i-1];
            assign dvs_in = dvs_reg[i-1];
            assign sat_in = sat_reg[i-1];
        end
        assign rem_sh = {rem_in, lo_in[Q_W-1]};
        assign ge     = (rem_sh >= {1'b0, dvs_in});
        assign diff   = rem_sh - {1'b0, dvs_in};
        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[i] <= ge ? diff[Q_W-1:0] : rem_sh[Q_W-1:0];
                lo_reg[i]  <= lo_in << 1;
                quo_reg[i] <= {quo_in[Q_W-2:0], ge};
                dvs_reg[i] <= dvs_in;
                sat_reg[i] <= sat_in;
            end
        end
    end

    assign quotient = sat_reg[DIV_LAT-1] ? {Q_W{1'b1}} : quo_reg[DIV_LAT-1];
    assign sat      = sat_reg[DIV_LAT-1];
endmodule

// ===== hdl/gmse_sqrt.sv =====
`timescale 1ns / 1ps
module gmse_sqrt #(
    parameter int FRAC_BITS = 32
) (
    input  logic                     aclk,
    input  logic                     en,
    input  logic [gmse_pkg::Q_W-1:0] radicand,
    output logic [gmse_pkg::Q_W-1:0] root
);
    import gmse_pkg::*;
    localparam int RW = Q_W + 2;

    logic [RW-1:0]    rem_reg  [SQRT_LAT];
    logic [Q_W-1:0]   root_reg [SQRT_LAT];
    logic [2*Q_W-1:0] x_reg    [SQRT_LAT];
    logic [2*Q_W-1:0] x_init;

    assign x_init = {{Q_W{1'b0}}, radicand} << FRAC_BITS;

    for (genvar i = 0; i < SQRT_LAT; i++) begin : g_step
        logic [RW-1:0]    rem_in;
        logic [Q_W-1:0]   root_in;
        logic [2*Q_W-1:0] x_in;
        logic [RW+1:0]    rem_sh, trial, diff;
        logic             ge;
        if (i == 0) begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign x_in    = x_init;
        end else begin : g_next
            assign rem_in  = rem_reg[i-1];
            assign root_in = root_reg[i-1];
            assign x_in    = x_reg[i-1];
        end
        assign rem_sh = {rem_in, x_in[2*Q_W-1 -: 2]};
        assign trial  = {2'b00, root_in, 2'b01};
        assign ge     = (rem_sh >= trial);
        assign diff   = rem_sh - trial;
        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[i]  <= ge ? diff[RW-1:0] : rem_sh[RW-1:0];
                root_reg[i] <= {root_in[Q_W-2:0], ge};
                x_reg[i]    <= x_in << 2;
            end
        end
    end

    assign root = root_reg[SQRT_LAT-1];
endmodule

// ===== hdl/gas_mixture_state_equation.sv =====
`timescale 1ns / 1ps
// Throughput: one transaction per cycle while the output buffer is not full; the path runs through three 64-stage
// restoring dividers in series, a 64-stage square root and 3-stage multipliers.
// A two-entry output buffer holds results; the pipeline stalls only when it is full.
// Reset (synchronous, active low) clears the valid chain and output buffer and
// loads the configuration registers with their default constants.
module gas_mixture_state_equation #(
    parameter int FRAC_BITS = 32
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // mix_density, internal_energy, erupted_fraction
    input  logic [gmse_pkg::S_TDATA_W-1:0]       s_tdata,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // heat_ratio, gas_pressure, sound_speed_out, temperature_out,
    // mix_heat_capacity, air_density, erupted_density, status
    output logic [gmse_pkg::M_TDATA_W-1:0]       m_tdata,
    input  logic                                 cfg_wr_en,
    input  logic [gmse_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [gmse_pkg::Q_W-1:0]             cfg_data
);
    import gmse_pkg::*;

    localparam logic [Q_W-1:0] ONE_Q   = 64'd1 << FRAC_BITS;
    localparam logic [Q_W-1:0] GFE_Q   = (ONE_Q * 64'd5 + 64'd50) / 64'd100;
    localparam logic [FRAC_IN_W-1:0] GFE_RST = GFE_Q[FRAC_IN_W-1:0];
    localparam logic [Q_W-1:0] CVS_RST = 64'd1100 << FRAC_BITS;
    localparam logic [Q_W-1:0] CVG_RST = 64'd1617 << FRAC_BITS;
    localparam logic [Q_W-1:0] CVA_RST = 64'd717 << FRAC_BITS;
    localparam logic [Q_W-1:0] RG_RST  = 64'd462 << FRAC_BITS;
    localparam logic [Q_W-1:0] RA_RST  = 64'd287 << FRAC_BITS;
    localparam int PIPE_LAT = 5 + 3 * MUL_LAT + 3 * DIV_LAT + SQRT_LAT;
    localparam int PAD_W    = M_TDATA_W - $bits(res_t);

    logic en;

    // configuration
    logic [FRAC_IN_W-1:0] gfe_reg;
    logic [Q_W-1:0] cvs_reg, cvg_reg, cva_reg, rg_reg, ra_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gfe_reg <= GFE_RST;
            cvs_reg <= CVS_RST;
            cvg_reg <= CVG_RST;
            cva_reg <= CVA_RST;
            rg_reg  <= RG_RST;
            ra_reg  <= RA_RST;
        end else if (cfg_wr_en) begin
            case (cfg_reg_t'(cfg_index))
                REG_GAS_FRACTION_ERUPTED: gfe_reg <= cfg_data[FRAC_IN_W-1:0];
                REG_HEAT_CAPACITY_SOLID:  cvs_reg <= cfg_data;
                REG_HEAT_CAPACITY_GAS:    cvg_reg <= cfg_data;
                REG_HEAT_CAPACITY_AIR:    cva_reg <= cfg_data;
                REG_GAS_CONSTANT_GAS:     rg_reg  <= cfg_data;
                REG_GAS_CONSTANT_AIR:     ra_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // stage 1: input capture and fraction clamps
    logic [Q_W-1:0] f_ext, g_ext;
    logic [Q_W-1:0] rho1_reg, e1_reg, f1_reg, ng01_reg;

    assign f_ext = {{(Q_W-FRAC_IN_W){1'b0}}, s_tdata[2*Q_W +: FRAC_IN_W]};
    assign g_ext = {{(Q_W-FRAC_IN_W){1'b0}}, gfe_reg};

    always_ff @(posedge aclk) begin
        if (en) begin
            rho1_reg <= s_tdata[0 +: Q_W];
            e1_reg   <= s_tdata[Q_W +: Q_W];
            f1_reg   <= (f_ext > ONE_Q) ? ONE_Q : f_ext;
            ng01_reg <= (g_ext > ONE_Q) ? ONE_Q : g_ext;
        end
    end

    logic [Q_W-1:0] ng4, erd4, rho4, e4, f4;
    logic           s_ng4, s_erd4;

    gmse_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_ng (.aclk, .en, .a(ng01_reg), .b(f1_reg),
        .p(ng4), .sat(s_ng4));
    gmse_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_erd (.aclk, .en, .a(rho1_reg), .b(f1_reg),
        .p(erd4), .sat(s_erd4));
    gmse_delay #(.W(3*Q_W), .D(MUL_LAT)) u_dl_a (.aclk, .en,
        .din({rho1_reg, e1_reg, f1_reg}), .dout({rho4, e4, f4}));

    // stage B: phase fractions
    logic [Q_W-1:0] ng5_reg, ns5_reg, na5_reg, gsum5_reg, rho5_reg, e5_reg, erd5_reg;
    logic           sat5_reg;
    logic [Q_W-1:0] na4;

    assign na4 = ONE_Q - f4;

    always_ff @(posedge aclk) begin
        if (en) begin
            ng5_reg   <= ng4;
            ns5_reg   <= f4 - ng4;
            na5_reg   <= na4;
            gsum5_reg <= ng4 + na4;
            rho5_reg  <= rho4;
            e5_reg    <= e4;
            erd5_reg  <= erd4;
            sat5_reg  <= s_ng4 | s_erd4;
        end
    end

    logic [Q_W-1:0] ms8, mg8, ma8, mrg8, mra8, des8, air8, gsum8, e8, erd8;
    logic           s_ms8, s_mg8, s_ma8, s_mrg8, s_mra8, s_des8, s_air8, sat5_8;

    gmse_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_s (.aclk, .en, .a(ns5_reg), .b(cvs_reg),
        .p(ms8), .sat(s_ms8));
    gmse_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_g (.aclk, .en, .a(ng5_reg), .b(cvg_reg),
        .p(mg8), .sat(s_mg8));
    gmse_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_a (.aclk, .en, .a(na5_reg), .b(cva_reg),
        .p(ma8), .sat(s_ma8));
    gmse_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_rg (.aclk, .en, .a(ng5_reg), .b(rg_reg),
        .p(mrg8), .sat(s_mrg8));
    gmse_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_ra (.aclk, .en, .a(na5_reg), .b(ra_reg),
        .p(mra8), .sat(s_mra8));
    gmse_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_des (.aclk, .en, .a(rho5_reg), .b(gsum5_reg),
        .p(des8), .sat(s_des8));
    gmse_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_air (.aclk, .en, .a(rho5_reg), .b(na5_reg),
        .p(air8), .sat(s_air8));
    gmse_delay #(.W(3*Q_W+1), .D(MUL_LAT)) u_dl_b (.aclk, .en,
        .din({gsum5_reg, e5_reg, erd5_reg, sat5_reg}), .dout({gsum8, e8, erd8, sat5_8}));

    // stage C: mixture sums
    qsum_t s1_8, cvm_8, rm_8, cvgs_8;
    logic [Q_W-1:0] cvm9_reg, rm9_reg, cvgs9_reg, des9_reg, air9_reg, erd9_reg;
    logic [Q_W-1:0] gsum9_reg, e9_reg;
    logic           sat9_reg;

    assign s1_8   = q_add(ms8, mg8);
    assign cvm_8  = q_add(s1_8.val, ma8);
    assign rm_8   = q_add(mrg8, mra8);
    assign cvgs_8 = q_add(mg8, ma8);

    always_ff @(posedge aclk) begin
        if (en) begin
            cvm9_reg  <= cvm_8.val;
            rm9_reg   <= rm_8.val;
            cvgs9_reg <= cvgs_8.val;
            des9_reg  <= des8;
            air9_reg  <= air8;
            erd9_reg  <= erd8;
            gsum9_reg <= gsum8;
            e9_reg    <= e8;
            sat9_reg  <= sat5_8 | s_ms8 | s_mg8 | s_ma8 | s_mrg8 | s_mra8 | s_des8
                       | s_air8 | s1_8.sat | cvm_8.sat | rm_8.sat | cvgs_8.sat;
        end
    end

    logic [Q_W-1:0] rmg73, cvmg73, g73, t73;
    logic           s_rmg73, s_cvmg73, s_g73, s_t73;
    logic [Q_W-1:0] cvm73, gsum73, des73, air73, erd73;
    logic           sat9_73;

    gmse_div #(.FRAC_BITS(FRAC_BITS)) u_div_rmg (.aclk, .en, .dividend(rm9_reg),
        .divisor(gsum9_reg), .quotient(rmg73), .sat(s_rmg73));
    gmse_div #(.FRAC_BITS(FRAC_BITS)) u_div_cvmg (.aclk, .en, .dividend(cvgs9_reg),
        .divisor(gsum9_reg), .quotient(cvmg73), .sat(s_cvmg73));
    gmse_div #(.FRAC_BITS(FRAC_BITS)) u_div_g (.aclk, .en, .dividend(rm9_reg),
        .divisor(cvm9_reg), .quotient(g73), .sat(s_g73));
    gmse_div #(.FRAC_BITS(FRAC_BITS)) u_div_t (.aclk, .en, .dividend(e9_reg),
        .divisor(cvm9_reg), .quotient(t73), .sat(s_t73));
    gmse_delay #(.W(5*Q_W+1), .D(DIV_LAT)) u_dl_c (.aclk, .en,
        .din({cvm9_reg, gsum9_reg, des9_reg, air9_reg, erd9_reg, sat9_reg}),
        .dout({cvm73, gsum73, des73, air73, erd73, sat9_73}));

    // stage E: gamma, temperature, zero-divisor flags
    qsum_t gam73;
    logic  zc73, zg73;
    logic [Q_W-1:0] gamma74_reg, temp74_reg, rmg74_reg, cvmg74_reg, cvm74_reg;
    logic [Q_W-1:0] des74_reg, air74_reg, erd74_reg;
    logic           sat74_reg, zc74_reg, zg74_reg, zs74_reg;

    assign gam73 = q_add(ONE_Q, g73);
    assign zc73  = (cvm73 == '0);
    assign zg73  = (gsum73 == '0);

    always_ff @(posedge aclk) begin
        if (en) begin
            gamma74_reg <= zc73 ? '0 : gam73.val;
            temp74_reg  <= zc73 ? '0 : t73;
            rmg74_reg   <= rmg73;
            cvmg74_reg  <= cvmg73;
            cvm74_reg   <= cvm73;
            des74_reg   <= des73;
            air74_reg   <= air73;
            erd74_reg   <= erd73;
            sat74_reg   <= sat9_73 | (!zg73 & (s_rmg73 | s_cvmg73))
                         | (!zc73 & (s_g73 | s_t73 | gam73.sat));
            zc74_reg    <= zc73;
            zg74_reg    <= zg73;
            zs74_reg    <= (cvmg73 == '0) || (des73 == '0);
        end
    end

    logic [Q_W-1:0] t1_77, temp77, press80, press138;
    logic           s_t1_77, s_t1_80, s_p80, psat138;

    gmse_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_t1 (.aclk, .en, .a(rmg74_reg), .b(des74_reg),
        .p(t1_77), .sat(s_t1_77));
    gmse_delay #(.W(Q_W), .D(MUL_LAT)) u_dl_temp (.aclk, .en, .din(temp74_reg),
        .dout(temp77));
    gmse_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_p (.aclk, .en, .a(t1_77), .b(temp77),
        .p(press80), .sat(s_p80));
    gmse_delay #(.W(1), .D(MUL_LAT)) u_dl_st1 (.aclk, .en, .din(s_t1_77), .dout(s_t1_80));
    gmse_delay #(.W(Q_W+1), .D(DIV_LAT-2*MUL_LAT)) u_dl_p (.aclk, .en,
        .din({press80, s_t1_80 | s_p80}), .dout({press138, psat138}));

    logic [Q_W-1:0] k138, gamma138, temp138, cvm138, des138, air138, erd138;
    logic           s_k138, sat138, zc138, zg138, zs138;

    gmse_div #(.FRAC_BITS(FRAC_BITS)) u_div_k (.aclk, .en, .dividend(rmg74_reg),
        .divisor(cvmg74_reg), .quotient(k138), .sat(s_k138));
    gmse_delay #(.W(6*Q_W+4), .D(DIV_LAT)) u_dl_e (.aclk, .en,
        .din({gamma74_reg, temp74_reg, cvm74_reg, des74_reg, air74_reg, erd74_reg,
              sat74_reg, zc74_reg, zg74_reg, zs74_reg}),
        .dout({gamma138, temp138, cvm138, des138, air138, erd138,
               sat138, zc138, zg138, zs138}));

    // stage F: sound speed factor
    qsum_t kadd138;
    logic  okp138, okall138;
    logic [Q_W-1:0] k139_reg, press139_reg, gamma139_reg, temp139_reg, cvm139_reg;
    logic [Q_W-1:0] des139_reg, air139_reg, erd139_reg;
    logic           sat139_reg, ok139_reg;

    assign kadd138  = q_add(ONE_Q, k138);
    assign okp138   = !zc138 && !zg138;
    assign okall138 = okp138 && !zs138;

    always_ff @(posedge aclk) begin
        if (en) begin
            k139_reg     <= kadd138.val;
            press139_reg <= okp138 ? press138 : '0;
            gamma139_reg <= gamma138;
            temp139_reg  <= temp138;
            cvm139_reg   <= cvm138;
            des139_reg   <= des138;
            air139_reg   <= air138;
            erd139_reg   <= erd138;
            sat139_reg   <= sat138 | (okp138 & psat138)
                          | (okall138 & (s_k138 | kadd138.sat));
            ok139_reg    <= okall138;
        end
    end

    logic [Q_W-1:0] kp142, des142, q206, root270;
    logic           s_kp142, s_kp206, s_q206, sat2_270;
    logic [Q_W-1:0] gamma270, press270, temp270, cvm270, air270, erd270;
    logic           sat270, ok270;

    gmse_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_kp (.aclk, .en, .a(k139_reg), .b(press139_reg),
        .p(kp142), .sat(s_kp142));
    gmse_delay #(.W(Q_W), .D(MUL_LAT)) u_dl_des (.aclk, .en, .din(des139_reg),
        .dout(des142));
    gmse_div #(.FRAC_BITS(FRAC_BITS)) u_div_s (.aclk, .en, .dividend(kp142),
        .divisor(des142), .quotient(q206), .sat(s_q206));
    gmse_delay #(.W(1), .D(DIV_LAT)) u_dl_skp (.aclk, .en, .din(s_kp142), .dout(s_kp206));
    gmse_sqrt #(.FRAC_BITS(FRAC_BITS)) u_sqrt (.aclk, .en, .radicand(q206), .root(root270));
    gmse_delay #(.W(1), .D(SQRT_LAT)) u_dl_s2 (.aclk, .en, .din(s_kp206 | s_q206),
        .dout(sat2_270));
    gmse_delay #(.W(6*Q_W+2), .D(MUL_LAT+DIV_LAT+SQRT_LAT)) u_dl_f (.aclk, .en,
        .din({gamma139_reg, press139_reg, temp139_reg, cvm139_reg, air139_reg,
              erd139_reg, sat139_reg, ok139_reg}),
        .dout({gamma270, press270, temp270, cvm270, air270, erd270, sat270, ok270}));

    res_t res270;
    logic satf270;

    assign satf270 = sat270 | (ok270 & sat2_270);

    always_comb begin
        res270.heat_ratio        = gamma270;
        res270.gas_pressure      = press270;
        res270.sound_speed_out   = ok270 ? root270 : '0;
        res270.temperature_out   = temp270;
        res270.mix_heat_capacity = cvm270;
        res270.air_density       = air270;
        res270.erupted_density   = erd270;
        res270.status            = !ok270 ? ST_DIV_ZERO : (satf270 ? ST_SAT : ST_OK);
    end

    // valid chain
    logic [PIPE_LAT-1:0] vld_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[PIPE_LAT-2:0], s_tvalid};
        end
    end

    // output buffer
    res_t       fifo_mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] fifo_cnt_reg, fifo_cnt_next;
    logic       push, pop;

    assign en       = (fifo_cnt_reg != 2'd2);
    assign s_tready = en;
    assign push     = en && vld_reg[PIPE_LAT-1];
    assign pop      = m_tvalid && m_tready;
    assign fifo_cnt_next = fifo_cnt_reg + {1'b0, push} - {1'b0, pop};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg   <= 1'b0;
            rd_ptr_reg   <= 1'b0;
            fifo_cnt_reg <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            fifo_cnt_reg <= fifo_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_mem_reg[wr_ptr_reg] <= res270;
        end
    end

    assign m_tvalid = (fifo_cnt_reg != 2'd0);
    assign m_tdata  = {{PAD_W{1'b0}}, fifo_mem_reg[rd_ptr_reg]};

`ifndef SYNTH
    a_push_not_full: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (fifo_cnt_reg != 2'd2))
        else $error("push into full output buffer");
    a_accept_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> vld_reg[0])
        else $error("accepted transaction missing from valid chain");
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(vld_reg))
        else $error("valid chain moved during stall");
    a_cnt_up: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> (fifo_cnt_reg == $past(fifo_cnt_reg) + 2'd1))
        else $error("output buffer count mismatch");
`endif
endmodule

// ===== verif/tb_gas_mixture_state_equation.sv =====
`timescale 1ns / 1ps
module tb_gas_mixture_state_equation;
    import gmse_pkg::*;

    localparam logic [63:0] ONE_Q = 64'd1 << 32;

    logic aclk;
    logic aresetn;
    logic s_tvalid;
    logic s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic m_tvalid;
    logic m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [Q_W-1:0] cfg_data;

    gas_mixture_state_equation dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // local copy of the material constants
    logic [63:0] gas_frac_q, cv_solid_q, cv_gas_q, cv_air_q, r_gas_q, r_air_q;

    logic [S_TDATA_W-1:0] particle_q[$];
    res_t state_q[$];
    bit jitter;
    bit sat_hit;
    int errors;

    initial begin
        aclk = 1'b0;
        forever begin
            #10 aclk = 1'b1;
            #10 aclk = 1'b0;
        end
    end

    function automatic logic [63:0] qadd(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s[64]) begin
            sat_hit = 1'b1;
            return '1;
        end
        return s[63:0];
    endfunction

    function automatic logic [63:0] qmul(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        if (p[127:96] != 0) begin
            sat_hit = 1'b1;
            return '1;
        end
        return p[95:32];
    endfunction

    function automatic logic [63:0] qdiv(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] q;
        if ((a >> 32) >= b) begin
            sat_hit = 1'b1;
            return '1;
        end
        q = {32'd0, a, 32'd0} / {64'd0, b};
        return q[63:0];
    endfunction

    function automatic logic [63:0] qsqrt(input logic [63:0] x);
        logic [127:0] v;
        logic [63:0] root;
        logic [63:0] c;
        v = {32'd0, x, 32'd0};
        root = 0;
        for (int i = 63; i >= 0; i--) begin
            c = root | (64'd1 << i);
            if ({64'd0, c} * {64'd0, c} <= v) root = c;
        end
        return root;
    endfunction

    function automatic res_t mixture_state(input logic [S_TDATA_W-1:0] d);
        logic [63:0] rho, energy, f, ng0, ng, ns, na, gsum, cvm, rm, rmg, cvg_sum, cvmg;
        logic [63:0] desmg, k;
        bit dz;
        res_t r;
        rho = d[63:0];
        energy = d[127:64];
        f = {31'd0, d[160:128]};
        ng0 = gas_frac_q;
        sat_hit = 1'b0;
        dz = 1'b0;
        rmg = 0;
        cvmg = 0;
        r = '0;
        if (f > ONE_Q) f = ONE_Q;
        if (ng0 > ONE_Q) ng0 = ONE_Q;
        ng = qmul(ng0, f);
        ns = f - ng;
        na = ONE_Q - f;
        gsum = ng + na;
        cvm = qadd(qadd(qmul(ns, cv_solid_q), qmul(ng, cv_gas_q)), qmul(na, cv_air_q));
        rm = qadd(qmul(ng, r_gas_q), qmul(na, r_air_q));
        cvg_sum = qadd(qmul(ng, cv_gas_q), qmul(na, cv_air_q));
        desmg = qmul(rho, gsum);
        if (gsum != 0) begin
            rmg = qdiv(rm, gsum);
            cvmg = qdiv(cvg_sum, gsum);
        end else begin
            dz = 1'b1;
        end
        if (cvm != 0) begin
            r.heat_ratio = qadd(ONE_Q, qdiv(rm, cvm));
            r.temperature_out = qdiv(energy, cvm);
            if (gsum != 0) r.gas_pressure = qmul(qmul(rmg, desmg), r.temperature_out);
        end else begin
            dz = 1'b1;
        end
        if (cvm != 0 && gsum != 0) begin
            if (cvmg != 0 && desmg != 0) begin
                k = qadd(ONE_Q, qdiv(rmg, cvmg));
                r.sound_speed_out = qsqrt(qdiv(qmul(k, r.gas_pressure), desmg));
            end else begin
                dz = 1'b1;
            end
        end
        r.mix_heat_capacity = cvm;
        r.air_density = qmul(rho, na);
        r.erupted_density = qmul(rho, f);
        r.status = dz ? ST_DIV_ZERO : (sat_hit ? ST_SAT : ST_OK);
        return r;
    endfunction

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) state_q.push_back(mixture_state(s_tdata));
            if (!s_tvalid || s_tready) begin
                if (particle_q.size() > 0 && !(jitter && $urandom_range(0, 99) < 11)) begin
                    s_tvalid <= 1'b1;
                    s_tdata <= particle_q.pop_front();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        res_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= !(jitter && $urandom_range(0, 99) < 11);
            if (m_tvalid && m_tready) begin
                if (state_q.size() == 0) begin
                    $display("%0t: unexpected transaction, actual %h", $time, m_tdata);
                    errors++;
                end else begin
                    want = state_q.pop_front();
                    for (int k = 0; k < 7; k++) begin
                        if (m_tdata[k*64 +: 64] != want[k*64 +: 64]) begin
                            $display("%0t: field %0d expected %h actual %h", $time, k,
                                     want[k*64 +: 64], m_tdata[k*64 +: 64]);
                            errors++;
                        end
                    end
                    if (m_tdata[449:448] != want.status) begin
                        $display("%0t: status expected %0d actual %0d", $time,
                                 want.status, m_tdata[449:448]);
                        errors++;
                    end
                end
            end
        end
    end

    task automatic set_reg(input cfg_reg_t idx, input logic [63:0] v);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        case (idx)
            REG_GAS_FRACTION_ERUPTED: gas_frac_q = {31'd0, v[32:0]};
            REG_HEAT_CAPACITY_SOLID:  cv_solid_q = v;
            REG_HEAT_CAPACITY_GAS:    cv_gas_q = v;
            REG_HEAT_CAPACITY_AIR:    cv_air_q = v;
            REG_GAS_CONSTANT_GAS:     r_gas_q = v;
            REG_GAS_CONSTANT_AIR:     r_air_q = v;
            default: ;
        endcase
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic drain();
        do @(negedge aclk);
        while (particle_q.size() != 0 || s_tvalid || state_q.size() != 0);
    endtask

    function automatic logic [63:0] rand_q();
        case ($urandom_range(0, 5))
            0: return {$urandom, $urandom};
            1: return 64'd0;
            2: return '1;
            3: return {20'd0, 12'($urandom_range(0, 4095)), $urandom};
            4: return {28'd0, 4'($urandom), $urandom};
            default: return {24'd0, 8'($urandom), $urandom};
        endcase
    endfunction

    function automatic logic [32:0] rand_frac();
        case ($urandom_range(0, 5))
            0: return 33'd0;
            1: return 33'h1_0000_0000;
            2: return {1'b1, $urandom};
            default: return {1'b0, $urandom};
        endcase
    endfunction

    task automatic add_particle(input logic [63:0] rho, input logic [63:0] e,
                                input logic [32:0] f);
        particle_q.push_back({7'd0, f, e, rho});
    endtask

    task automatic random_particles(input int n);
        for (int i = 0; i < n; i++) add_particle(rand_q(), rand_q(), rand_frac());
    endtask

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        jitter = 1'b0;
        errors = 0;
        gas_frac_q = 64'd214748365;
        cv_solid_q = 64'd4724464025600;
        cv_gas_q = 64'd6944962117632;
        cv_air_q = 64'd3079491551232;
        r_gas_q = 64'd1984274890752;
        r_air_q = 64'd1232655613952;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // defaults: field extremes, all air, all erupted, fraction above one
        add_particle(64'd0, 64'd0, 33'd0);
        add_particle('1, '1, 33'h1_0000_0000);
        add_particle('1, '1, 33'd0);
        add_particle(64'd1 << 32, 64'd300 << 32, 33'd0);
        add_particle(64'd1 << 32, 64'd300 << 32, 33'h1_0000_0000);
        add_particle(64'd5 << 32, 64'd1000 << 32, 33'h0_8000_0000);
        add_particle(64'd2 << 32, 64'd500 << 32, 33'h1_FFFF_FFFF);
        add_particle(64'd0, 64'd500 << 32, 33'h0_4000_0000);
        add_particle(64'd1, 64'd1, 33'd1);
        add_particle(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 33'h1_5555_5555);
        add_particle(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 33'h0_AAAA_AAAA);
        random_particles(120);
        drain();
        jitter = 1'b1;
        random_particles(130);
        drain();

        // no erupted gas, no solid cv: all-erupted particles divide by zero
        set_reg(REG_GAS_FRACTION_ERUPTED, 64'd0);
        set_reg(REG_HEAT_CAPACITY_SOLID, 64'd0);
        @(negedge aclk);
        add_particle(64'd3 << 32, 64'd400 << 32, 33'h1_0000_0000);
        add_particle(64'd3 << 32, 64'd400 << 32, 33'h0_C000_0000);
        random_particles(60);
        drain();

        // gas cv, air cv and both gas constants zero: gas heat capacity vanishes
        set_reg(REG_GAS_FRACTION_ERUPTED, 64'h1_FFFF_FFFF);
        set_reg(REG_HEAT_CAPACITY_SOLID, 64'd1100 << 32);
        set_reg(REG_HEAT_CAPACITY_GAS, 64'd0);
        set_reg(REG_HEAT_CAPACITY_AIR, 64'd0);
        set_reg(REG_GAS_CONSTANT_GAS, 64'd0);
        set_reg(REG_GAS_CONSTANT_AIR, 64'd0);
        @(negedge aclk);
        add_particle(64'd3 << 32, 64'd400 << 32, 33'h0_4000_0000);
        random_particles(50);
        drain();

        // all constants at maximum
        set_reg(REG_HEAT_CAPACITY_SOLID, '1);
        set_reg(REG_HEAT_CAPACITY_GAS, '1);
        set_reg(REG_HEAT_CAPACITY_AIR, '1);
        set_reg(REG_GAS_CONSTANT_GAS, '1);
        set_reg(REG_GAS_CONSTANT_AIR, '1);
        @(negedge aclk);
        random_particles(50);
        drain();

        // random constants
        for (int p = 0; p < 3; p++) begin
            set_reg(REG_GAS_FRACTION_ERUPTED, {31'd0, rand_frac()});
            set_reg(REG_HEAT_CAPACITY_SOLID, rand_q());
            set_reg(REG_HEAT_CAPACITY_GAS, rand_q());
            set_reg(REG_HEAT_CAPACITY_AIR, rand_q());
            set_reg(REG_GAS_CONSTANT_GAS, rand_q());
            set_reg(REG_GAS_CONSTANT_AIR, rand_q());
            @(negedge aclk);
            random_particles(45);
            drain();
        end

        repeat (300) @(posedge aclk);
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
